@@ rtl/fic_pkg.sv @@
// ----------------------------------------------------------------------------
// fic_pkg: shared types and constants for the comb filter
// Beat payloads, register indexes and sequencer states of the filter.
// ----------------------------------------------------------------------------
package fic_pkg;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 16;
   localparam int SPREAD_W = 17;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
   localparam logic [SPREAD_W-1:0]        SPREAD_ONE = 17'h10000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [GAIN_W-1:0]          envelope;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIRECT_GAIN   = 3'd0,
      CSR_DELAYED_GAIN  = 3'd1,
      CSR_AMP_GAIN      = 3'd2,
      CSR_FEEDBACK_MODE = 3'd3,
      CSR_DELAY_LENGTH  = 3'd4,
      CSR_SPREAD        = 3'd5,
      CSR_STEREO        = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ADDR,
      ST_MUL0,
      ST_MUL1,
      ST_RND,
      ST_LO,
      ST_HI,
      ST_SAT,
      ST_LEFT,
      ST_RIGHT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/fir_iir_comb_filter.sv @@
// ----------------------------------------------------------------------------
// fir_iir_comb_filter: feedforward or feedback audio comb filter
// One shared multiplier under a small sequencer computes the gained sum, the
// envelope and amplitude scaling, saturation and the stereo split.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  req      in         req_valid / req_stall    req_data  (req_type)
//  rsp      out        rsp_valid / rsp_stall    rsp_data  (rsp_type)
//  csr      in         csr_valid / csr_ready    csr_index, csr_wdata
//
// After its beat is accepted, a sample steps through the ADDR, MUL0, MUL1, RND,
// LO, HI, SAT, LEFT, RIGHT and DONE states into the result register, preceded
// by REDUCE when delay_length is at least HISTORY_DEPTH. The next beat is taken
// in IDLE. The single multiplier and registered history read set this sequence.
// Reset is synchronous; the histories read as zero until written, so no
// clearing pass is needed. A result waits in the output register while the
// next sample is taken; a second finished result waits until that one leaves.
// ----------------------------------------------------------------------------
module fir_iir_comb_filter
   import fic_pkg::*;
#(
   parameter int HISTORY_DEPTH = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SPREAD_W-1:0]  csr_wdata
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW = ((AW > 16) ? AW : 16) + 1;
   localparam logic [16:0] DEPTH17 =
      17'((HISTORY_DEPTH > 65535) ? 65536 : HISTORY_DEPTH);
   localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

   // Configuration registers.
   logic signed [15:0] direct_gain_ff, direct_gain_in;
   logic signed [15:0] delayed_gain_ff, delayed_gain_in;
   logic [15:0]        amp_gain_ff, amp_gain_in;
   logic               feedback_mode_ff, feedback_mode_in;
   logic [15:0]        delay_length_ff, delay_length_in;
   logic [16:0]        spread_ff, spread_in;
   logic               stereo_ff, stereo_in;

   // Sequencer and datapath.
   state_type             state_ff, state_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic                  wrapped_ff, wrapped_in;
   logic [15:0]           rem_ff, rem_in;
   logic [3:0]            red_cnt_ff, red_cnt_in;
   logic signed [23:0]    x_ff, x_in;
   logic [15:0]           env_ff, env_in;
   logic signed [58:0]    acc_ff, acc_in;
   logic signed [26:0]    a_ff, a_in;
   logic [31:0]           g_ff, g_in;
   logic signed [23:0]    y_ff, y_in;
   logic signed [23:0]    left_ff, left_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic signed [27:0]    mul_a;
   logic signed [17:0]    mul_b;
   logic signed [45:0]    mul_p;

   logic                  accept;
   logic                  in_wr_en;
   logic                  out_wr_en;
   logic [15:0]           rem_shift;
   logic [CW-1:0]         wp_ext, d_ext, rd_full;
   logic [AW-1:0]         rd_addr;
   logic                  in_ok, out_ok;
   logic signed [23:0]    in_rd_ff, out_rd_ff;
   logic signed [23:0]    dl;
   logic [16:0]           s_eff;
   logic signed [58:0]    acc_r14, acc_r27, acc_r16;
   logic signed [31:0]    q27;
   logic signed [23:0]    y_sat;

   logic signed [23:0]    in_mem  [HISTORY_DEPTH];
   logic signed [23:0]    out_mem [HISTORY_DEPTH];

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Read address: (write pointer - reduced delay) modulo depth.
   assign wp_ext  = CW'(wp_ff);
   assign d_ext   = CW'(rem_ff);
   assign rd_full = ((wp_ext >= d_ext) ? wp_ext : wp_ext + CW'(HISTORY_DEPTH)) - d_ext;
   assign rd_addr = rd_full[AW-1:0];
   assign in_ok   = wrapped_ff || (rd_addr <= wp_ff);
   assign out_ok  = wrapped_ff || (rd_addr < wp_ff);
   assign dl      = feedback_mode_ff ? (out_ok ? out_rd_ff : '0)
                                     : (in_ok ? in_rd_ff : '0);

   assign rem_shift = rem_ff >> red_cnt_ff;
   assign s_eff     = (!stereo_ff || spread_ff > SPREAD_ONE) ? SPREAD_ONE : spread_ff;
   assign mul_p     = mul_a * mul_b;

   assign acc_r14 = acc_ff + 59'sd8192;
   assign acc_r27 = acc_ff + 59'sd67108864;
   assign acc_r16 = acc_ff + 59'sd32768;
   assign q27     = $signed(acc_r27[58:27]);
   assign y_sat   = (q27 > 32'(SAMPLE_MAX)) ? SAMPLE_MAX :
                    (q27 < 32'(SAMPLE_MIN)) ? SAMPLE_MIN : q27[23:0];

   always_ff @(posedge clock) begin
      if (in_wr_en) begin
         in_mem[wp_ff] <= req_data.sample_in;
      end
      in_rd_ff <= in_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (out_wr_en) begin
         out_mem[wp_ff] <= y_sat;
      end
      out_rd_ff <= out_mem[rd_addr];
   end

   always_comb begin
      direct_gain_in   = direct_gain_ff;
      delayed_gain_in  = delayed_gain_ff;
      amp_gain_in      = amp_gain_ff;
      feedback_mode_in = feedback_mode_ff;
      delay_length_in  = delay_length_ff;
      spread_in        = spread_ff;
      stereo_in        = stereo_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIRECT_GAIN:   direct_gain_in   = $signed(csr_wdata[15:0]);
            CSR_DELAYED_GAIN:  delayed_gain_in  = $signed(csr_wdata[15:0]);
            CSR_AMP_GAIN:      amp_gain_in      = csr_wdata[15:0];
            CSR_FEEDBACK_MODE: feedback_mode_in = csr_wdata[0];
            CSR_DELAY_LENGTH:  delay_length_in  = csr_wdata[15:0];
            CSR_SPREAD:        spread_in        = csr_wdata;
            CSR_STEREO:        stereo_in        = csr_wdata[0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      rem_in       = rem_ff;
      red_cnt_in   = red_cnt_ff;
      x_in         = x_ff;
      env_in       = env_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      g_in         = g_ff;
      y_in         = y_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      in_wr_en     = 1'b0;
      out_wr_en    = 1'b0;
      mul_a        = 28'(x_ff);
      mul_b        = 18'(direct_gain_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               in_wr_en   = 1'b1;
               x_in       = req_data.sample_in;
               env_in     = req_data.envelope;
               rem_in     = delay_length_ff;
               red_cnt_in = 4'd15;
               state_in   = (32'(delay_length_ff) >= 32'(HISTORY_DEPTH)) ? ST_REDUCE
                                                                         : ST_ADDR;
            end
         end
         ST_REDUCE: begin
            if (17'(rem_shift) >= DEPTH17) begin
               rem_in = rem_ff - 16'(32'(DEPTH17) << red_cnt_ff);
            end
            red_cnt_in = red_cnt_ff - 4'd1;
            if (red_cnt_ff == 4'd0) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_MUL0;
         end
         ST_MUL0: begin
            mul_a    = 28'(x_ff);
            mul_b    = 18'(direct_gain_ff);
            acc_in   = 59'(mul_p);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            mul_a    = 28'(dl);
            mul_b    = 18'(delayed_gain_ff);
            acc_in   = acc_ff + 59'(mul_p);
            state_in = ST_RND;
         end
         ST_RND: begin
            mul_a    = $signed({12'd0, env_ff});
            mul_b    = $signed({2'd0, amp_gain_ff});
            g_in     = mul_p[31:0];
            a_in     = $signed(acc_r14[40:14]);
            state_in = ST_LO;
         end
         ST_LO: begin
            mul_a    = 28'(a_ff);
            mul_b    = $signed({2'd0, g_ff[15:0]});
            acc_in   = 59'(mul_p);
            state_in = ST_HI;
         end
         ST_HI: begin
            mul_a    = 28'(a_ff);
            mul_b    = $signed({2'd0, g_ff[31:16]});
            acc_in   = acc_ff + (59'(mul_p) <<< 16);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            y_in      = y_sat;
            out_wr_en = 1'b1;
            if (wp_ff == WP_LAST) begin
               wp_in      = '0;
               wrapped_in = 1'b1;
            end else begin
               wp_in = wp_ff + AW'(1);
            end
            state_in = ST_LEFT;
         end
         ST_LEFT: begin
            mul_a    = 28'(y_ff);
            mul_b    = $signed({1'b0, s_eff});
            acc_in   = 59'(mul_p);
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            left_in  = $signed(acc_r16[39:16]);
            mul_a    = 28'(y_ff);
            mul_b    = $signed({1'b0, SPREAD_ONE - s_eff});
            acc_in   = 59'(mul_p);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.left_out  = left_ff;
               rsp_data_in.right_out = $signed(acc_r16[39:16]);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direct_gain_ff   <= 16'sd16384;
         delayed_gain_ff  <= 16'sd16384;
         amp_gain_ff      <= 16'd4096;
         feedback_mode_ff <= 1'b0;
         delay_length_ff  <= 16'd100;
         spread_ff        <= 17'd32768;
         stereo_ff        <= 1'b1;
         state_ff         <= ST_IDLE;
         wp_ff            <= '0;
         wrapped_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         direct_gain_ff   <= direct_gain_in;
         delayed_gain_ff  <= delayed_gain_in;
         amp_gain_ff      <= amp_gain_in;
         feedback_mode_ff <= feedback_mode_in;
         delay_length_ff  <= delay_length_in;
         spread_ff        <= spread_in;
         stereo_ff        <= stereo_in;
         state_ff         <= state_in;
         wp_ff            <= wp_in;
         wrapped_ff       <= wrapped_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      red_cnt_ff  <= red_cnt_in;
      x_ff        <= x_in;
      env_ff      <= env_in;
      acc_ff      <= acc_in;
      a_ff        <= a_in;
      g_ff        <= g_in;
      y_ff        <= y_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start the sequencer");

   a_wp_moves_on_sat: assert property (@(posedge clock) disable iff (reset)
      !$stable(wp_ff) |-> ($past(reset) || $past(state_ff) == ST_SAT))
      else $error("write pointer moved outside the saturation step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result beat raised without a finished sample");

   a_delay_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR) |-> (17'(rem_ff) < DEPTH17))
      else $error("delay not reduced below history depth");
`endif

endmodule

@@ sim/fir_iir_comb_filter_test.sv @@
// ----------------------------------------------------------------------------
// fir_iir_comb_filter_test: self-checking bench for the comb filter
// Drives samples and register writes into the filter, predicts every output
// beat from its own copy of the histories and registers, and compares each
// beat field by field under random idling, a long output hold-off and a drain.
// ----------------------------------------------------------------------------
module fir_iir_comb_filter_test;
   import fic_pkg::*;

   localparam int HIST_DEPTH     = 65536;
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_PRINTED    = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SPREAD_W-1:0]  csr_wdata = '0;

   logic signed [SAMPLE_W-1:0] in_hist [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] out_hist [HIST_DEPTH];
   logic [15:0]                write_ptr;
   logic signed [GAIN_W-1:0]   dir_gain;
   logic signed [GAIN_W-1:0]   dly_gain;
   logic [GAIN_W-1:0]          amp;
   logic                       fb_mode;
   logic [15:0]                delay_len;
   logic [SPREAD_W-1:0]        spread_q;
   logic                       stereo_en;

   rsp_type pending_outputs[$];
   rsp_type want;
   int      mismatches = 0;
   int      rsp_beats = 0;
   int      quiet_cycles = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      hold_off_cycles = 0;

   fir_iir_comb_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic void reset_filter_state();
      for (int i = 0; i < HIST_DEPTH; i++) begin
         in_hist[i] = '0;
         out_hist[i] = '0;
      end
      write_ptr = '0;
      dir_gain = 16'sd16384;
      dly_gain = 16'sd16384;
      amp = 16'd4096;
      fb_mode = 1'b0;
      delay_len = 16'd100;
      spread_q = 17'd32768;
      stereo_en = 1'b1;
   endfunction

   function automatic rsp_type filter_sample(req_type s);
      logic [15:0] rd;
      longint      x, dl, acc, g, y, sp;
      rsp_type     r;
      x = longint'(s.sample_in);
      rd = write_ptr - delay_len;
      in_hist[write_ptr] = s.sample_in;
      dl = fb_mode ? longint'(out_hist[rd]) : longint'(in_hist[rd]);
      acc = round_shift(longint'(dir_gain) * x + longint'(dly_gain) * dl, 14);
      g = longint'(s.envelope) * longint'(amp);
      y = round_shift(acc * g, 27);
      if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
      if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
      out_hist[write_ptr] = y[SAMPLE_W-1:0];
      write_ptr = write_ptr + 16'd1;
      if (stereo_en) begin
         sp = (spread_q > SPREAD_ONE) ? longint'(SPREAD_ONE) : longint'(spread_q);
         r.left_out = SAMPLE_W'(round_shift(y * sp, 16));
         r.right_out = SAMPLE_W'(round_shift(y * (65536 - sp), 16));
      end else begin
         r.left_out = y[SAMPLE_W-1:0];
         r.right_out = '0;
      end
      return r;
   endfunction

   function automatic req_type sample_of(logic signed [SAMPLE_W-1:0] x, logic [GAIN_W-1:0] e);
      req_type s;
      s.sample_in = x;
      s.envelope = e;
      return s;
   endfunction

   function automatic req_type random_sample();
      req_type s;
      case ($urandom_range(9))
         0: s.sample_in = SAMPLE_MAX;
         1: s.sample_in = SAMPLE_MIN;
         2: s.sample_in = 24'($urandom_range(0, 511) - 256);
         default: s.sample_in = 24'($urandom);
      endcase
      case ($urandom_range(7))
         0: s.envelope = '0;
         1: s.envelope = 16'd32768;
         2: s.envelope = 16'($urandom);
         default: s.envelope = 16'($urandom_range(0, 32768));
      endcase
      return s;
   endfunction

   function automatic logic [SPREAD_W-1:0] random_gain();
      if ($urandom_range(1))
         return 17'($urandom);
      return 17'($urandom_range(0, 32768) - 16384);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("mismatch: %s", msg);
   endtask

   task automatic send_sample(input req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      pending_outputs.push_back(filter_sample(item));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [SPREAD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIRECT_GAIN:   dir_gain = value[GAIN_W-1:0];
         CSR_DELAYED_GAIN:  dly_gain = value[GAIN_W-1:0];
         CSR_AMP_GAIN:      amp = value[GAIN_W-1:0];
         CSR_FEEDBACK_MODE: fb_mode = value[0];
         CSR_DELAY_LENGTH:  delay_len = value[15:0];
         CSR_SPREAD:        spread_q = value;
         CSR_STEREO:        stereo_en = value[0];
         default: ;
      endcase
   endtask

   task automatic configure_filter(input logic [SPREAD_W-1:0] dg, lg, ag, fb, dly, spr, st);
      wait_drained();
      write_register(CSR_DIRECT_GAIN, dg);
      write_register(CSR_DELAYED_GAIN, lg);
      write_register(CSR_AMP_GAIN, ag);
      write_register(CSR_FEEDBACK_MODE, fb);
      write_register(CSR_DELAY_LENGTH, dly);
      write_register(CSR_SPREAD, spr);
      write_register(CSR_STEREO, st);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   task automatic test_default_registers();
      send_sample(sample_of(SAMPLE_MAX, 16'd32768));
      send_sample(sample_of(SAMPLE_MIN, 16'd32768));
      send_sample(sample_of(24'sd0, 16'd0));
      send_sample(sample_of(-24'sd1, 16'hFFFF));
      send_sample(sample_of(24'sd1, 16'hFFFF));
      send_sample(sample_of(SAMPLE_MAX, 16'hFFFF));
   endtask

   task automatic test_register_extremes();
      configure_filter(17'h07FFF, 17'h08000, 17'h0FFFF, 17'd1, 17'd1, 17'h10000, 17'd1);
      send_sample(sample_of(SAMPLE_MAX, 16'hFFFF));
      send_sample(sample_of(SAMPLE_MIN, 16'hFFFF));
      send_sample(sample_of(24'sd12345, 16'd32768));
      send_sample(sample_of(-24'sd777, 16'd100));
      configure_filter(17'h08000, 17'h07FFF, 17'd1, 17'd0, 17'd0, 17'h1FFFF, 17'd0);
      send_sample(sample_of(SAMPLE_MAX, 16'hFFFF));
      send_sample(sample_of(SAMPLE_MIN, 16'hFFFF));
      send_sample(sample_of(24'sd1, 16'd32768));
      send_sample(sample_of(-24'sd1, 16'd1));
      configure_filter(17'd16384, 17'd16384, 17'd4096, 17'd1, 17'd0, 17'd0, 17'd1);
      send_sample(sample_of(24'sd4000000, 16'd32768));
      send_sample(sample_of(-24'sd4000000, 16'd32768));
      send_sample(sample_of(24'sd99, 16'd20000));
      configure_filter(17'h0C000, 17'h04000, 17'h01000, 17'd1, 17'hFFFF, 17'd49152, 17'd1);
      send_sample(sample_of(SAMPLE_MAX, 16'd32768));
      send_sample(sample_of(SAMPLE_MIN, 16'd32768));
      send_sample(sample_of(24'sd5, 16'd3));
   endtask

   task automatic test_random_filtering(input int phases, input int per_phase);
      logic [SPREAD_W-1:0] ag, dly, spr;
      for (int p = 0; p < phases; p++) begin
         ag = $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(1024, 8192));
         case ($urandom_range(7))
            0: dly = 17'd0;
            1: dly = 17'hFFFF;
            2: dly = 17'($urandom_range(0, 65535));
            default: dly = 17'($urandom_range(1, 48));
         endcase
         spr = $urandom_range(9) == 0 ? 17'($urandom_range(65537, 131071))
                                      : 17'($urandom_range(0, 65536));
         configure_filter(random_gain(), random_gain(), ag, 17'($urandom), dly, spr,
                          17'($urandom));
         repeat (per_phase) send_sample(random_sample());
      end
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 300;
      repeat (30) send_sample(random_sample());
      wait_drained();
      repeat (30) send_sample(random_sample());
   endtask

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_outputs.size() == 0) begin
               report_mismatch($sformatf("beat %0d arrived with nothing expected", rsp_beats));
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_data.left_out !== want.left_out)
                  report_mismatch($sformatf("beat %0d left_out got %h want %h",
                                            rsp_beats, rsp_data.left_out, want.left_out));
               if (rsp_data.right_out !== want.right_out)
                  report_mismatch($sformatf("beat %0d right_out got %h want %h",
                                            rsp_beats, rsp_data.right_out, want.right_out));
            end
            rsp_beats++;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("fir_iir_comb_filter regression: fail");
      $finish;
   end

   initial begin
      reset_filter_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(7, 46);
      test_default_registers();
      test_register_extremes();
      test_random_filtering(4, 60);
      test_backpressure();
      set_idling(46, 7);
      test_random_filtering(4, 60);
      set_idling(0, 0);
      test_random_filtering(4, 60);
      wait_drained();
      if (mismatches == 0 && pending_outputs.size() == 0)
         $display("fir_iir_comb_filter regression: pass");
      else
         $display("fir_iir_comb_filter regression: fail");
      $finish;
   end

endmodule
